[hdl/tbc_pkg.sv]
// tbc_pkg: shared widths, constants, register indexes and helpers for the
// transformer burden calculator. No dependencies.
`timescale 1ns / 1ps

package tbc_pkg;

    localparam int MUL_W  = 64;
    localparam int PROD_W = 2 * MUL_W;
    localparam int DIV_NW = 96;
    localparam int DIV_DW = 81;
    localparam int DIV_QW = 48;
    localparam int SQ_IW  = 128;
    localparam int SQ_RW  = 64;
    localparam int SQ_CW  = $clog2(SQ_RW + 1);

    localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;

    typedef enum logic [2:0] {
        REG_MODE   = 3'd0,
        REG_RANGE  = 3'd1,
        REG_NOMBUR = 3'd2,
        REG_LENGTH = 3'd3,
        REG_CROSS  = 3'd4
    } reg_index_t;

    function automatic logic [31:0] abs32(input logic [31:0] v);
        abs32 = v[31] ? (~v + 32'd1) : v;
    endfunction

endpackage

[hdl/tbc_mul.sv]
// tbc_mul: 64x64 unsigned multiplier built from one 32x32 multiplier over
// four partial products. Depends on tbc_pkg.
`timescale 1ns / 1ps

module tbc_mul
    import tbc_pkg::*;
#(
    parameter int W = MUL_W
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [W-1:0]      a,
    input  logic [W-1:0]      b,
    output logic              done,
    output logic [2*W-1:0]    prod
);

    localparam int H = W / 2;

    logic           run_reg;
    logic           done_reg;
    logic [2:0]     cnt_reg;
    logic [W-1:0]   a_reg;
    logic [W-1:0]   b_reg;
    logic [W-1:0]   pp_reg;
    logic [2*W-1:0] acc_reg;
    logic [1:0]     sel;
    logic [1:0]     wgt;
    logic [H-1:0]   a_part;
    logic [H-1:0]   b_part;
    logic [2*W-1:0] pp_shifted;

    assign sel    = cnt_reg[2:1];
    assign wgt    = {1'b0, sel[1]} + {1'b0, sel[0]};
    assign a_part = sel[1] ? a_reg[W-1:H] : a_reg[H-1:0];
    assign b_part = sel[0] ? b_reg[W-1:H] : b_reg[H-1:0];
    assign pp_shifted = {{W{1'b0}}, pp_reg} << (wgt * H);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg == 3'd7)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (run_reg)
        begin
            if (!cnt_reg[0])
            begin
                pp_reg <= a_part * b_part;
            end
            else
            begin
                acc_reg <= acc_reg + pp_shifted;
            end
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

[hdl/tbc_div.sv]
// tbc_div: restoring divider, one quotient bit per cycle, saturating.
// Depends on tbc_pkg.
`timescale 1ns / 1ps

module tbc_div
    import tbc_pkg::*;
#(
    parameter int NW = DIV_NW,
    parameter int DW = DIV_DW,
    parameter int QW = DIV_QW
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [QW-1:0] quo,
    output logic          err
);

    localparam int CW = $clog2(NW);

    logic          run_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [NW-1:0] num_reg;
    logic [DW-1:0] den_reg;
    logic [DW-1:0] rem_reg;
    logic [QW:0]   q_reg;
    logic          sat_reg;
    logic [DW:0]   rem_sh;
    logic [DW+1:0] diff;
    logic          ge;
    logic [QW:0]   q_next;

    assign rem_sh = {rem_reg, num_reg[NW-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, den_reg};
    assign ge     = !diff[DW+1];
    assign q_next = {q_reg[QW-1:0], ge};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                if (den == '0)
                begin
                    done_reg <= 1'b1;
                end
                else
                begin
                    run_reg <= 1'b1;
                    cnt_reg <= CW'(NW - 1);
                end
            end
            else if (run_reg)
            begin
                if (cnt_reg == '0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
            q_reg   <= '0;
            sat_reg <= (den == '0);
        end
        else if (run_reg)
        begin
            num_reg <= num_reg << 1;
            rem_reg <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
            q_reg   <= q_next;
            sat_reg <= sat_reg | q_next[QW];
        end
    end

    assign done = done_reg;
    assign quo  = sat_reg ? {QW{1'b1}} : q_reg[QW-1:0];
    assign err  = sat_reg;

endmodule

[hdl/tbc_sqrt.sv]
// tbc_sqrt: digit-by-digit integer square root, one root bit per cycle.
// Depends on tbc_pkg.
`timescale 1ns / 1ps

module tbc_sqrt
    import tbc_pkg::*;
#(
    parameter int IW = SQ_IW,
    parameter int RW = SQ_RW,
    parameter int CW = SQ_CW
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [IW-1:0] rad,
    input  logic [CW-1:0] iters,
    output logic          done,
    output logic [RW-1:0] root
);

    logic          run_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [IW-1:0] rad_reg;
    logic [RW:0]   rem_reg;
    logic [RW-1:0] root_reg;
    logic [RW+2:0] rem_sh;
    logic [RW+2:0] trial;
    logic [RW+2:0] diff;
    logic          ge;

    assign rem_sh = {rem_reg, rad_reg[IW-1:IW-2]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign ge     = (rem_sh >= trial);
    assign diff   = rem_sh - trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= iters - 1'b1;
            end
            else if (run_reg)
            begin
                if (cnt_reg == '0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= rad;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (run_reg)
        begin
            rad_reg  <= rad_reg << 2;
            rem_reg  <= ge ? diff[RW:0] : rem_sh[RW:0];
            root_reg <= {root_reg[RW-2:0], ge};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

[hdl/transformer_burden_calculator_core.sv]
// Channel  | Handshake            | Payload
// request  | in_valid / in_ready  | opcode, vector_real, vector_imag
// result   | out_valid / out_ready| burden, power_factor, relative_burden, error_flag
// config   | cfg_we               | cfg_addr, cfg_data
//
// A request's time from acceptance to out_valid is dominated by up to four
// passes through the 96-step shared divider, plus root extractions and
// multiplies. Fewer passes when the cross-section is zero or the current
// is zero in current mode.
// in_ready is high only while the sequencer is idle. A held result stalls the
// sequencer at its last step until out_ready. Reset clears the stored vectors.
// Depends on tbc_pkg, tbc_mul, tbc_div, tbc_sqrt.
`timescale 1ns / 1ps

module transformer_burden_calculator_core
    import tbc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        opcode,
    input  logic [31:0] vector_real,
    input  logic [31:0] vector_imag,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [47:0] burden,
    output logic [15:0] power_factor,
    output logic [47:0] relative_burden,
    output logic        error_flag,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_data
);

    typedef enum logic [16:0] {
        S_IDLE    = 17'h00001,
        S_SQ_RE   = 17'h00002,
        S_SQ_IM   = 17'h00004,
        S_RMS     = 17'h00008,
        S_RES     = 17'h00010,
        S_NSQ     = 17'h00020,
        S_B_MUL1  = 17'h00040,
        S_B_MUL2  = 17'h00080,
        S_B_DIV   = 17'h00100,
        S_B_MUL3  = 17'h00200,
        S_REL     = 17'h00400,
        S_PF_M1   = 17'h00800,
        S_PF_M2   = 17'h01000,
        S_PF_M3   = 17'h02000,
        S_PF_SQRT = 17'h04000,
        S_PF_DIV  = 17'h08000,
        S_FIN     = 17'h10000
    } state_t;

    state_t state_reg, state_next;
    logic   go_reg;
    logic   ovalid_reg;

    logic        mode_reg;
    logic [31:0] range_reg, nombur_reg, length_reg, cross_reg;
    logic [31:0] vr_reg, vi_reg, cr_reg, ci_reg;
    logic [31:0] u_reg, i_reg;
    logic [63:0] msqv_reg, msqi_reg;

    logic        op_reg;
    logic [31:0] re_reg, im_reg;
    logic        err_reg;
    logic [63:0] msq_reg;
    logic [47:0] r_reg;
    logic [63:0] n2_reg;
    logic [DIV_NW-1:0] num_reg;
    logic [DIV_DW-1:0] den_reg;
    logic [47:0] bur_reg, rel_reg;
    logic [63:0] p1_reg, mag_reg, s_reg;
    logic        neg_reg;
    logic [PROD_W-1:0] sq_reg;
    logic [15:0] pf_reg;
    logic [47:0] o_bur_reg, o_rel_reg;
    logic [15:0] o_pf_reg;
    logic        o_err_reg;

    logic              mul_start, mul_done;
    logic [MUL_W-1:0]  mul_a, mul_b;
    logic [PROD_W-1:0] mul_p;
    logic              div_start, div_done, div_err;
    logic [DIV_NW-1:0] div_num;
    logic [DIV_DW-1:0] div_den;
    logic [DIV_QW-1:0] div_q;
    logic              sq_start, sq_done;
    logic [SQ_IW-1:0]  sq_rad;
    logic [SQ_CW-1:0]  sq_iters;
    logic [SQ_RW-1:0]  sq_root;

    logic        accept, deliver;
    logic        cross_zero, i_zero;
    logic [31:0] irp, iip, vrp, vip;
    logic [63:0] msqi_p, msqv_p;
    logic        s1, s2;
    logic [65:0] dot;
    logic [37:0] cross56;
    logic [54:0] bur100;
    logic [48:0] bsum;
    logic [47:0] t2;
    logic [16:0] qc;

    assign accept  = in_valid && in_ready;
    assign deliver = (state_reg == S_FIN) && (!ovalid_reg || out_ready);
    assign in_ready = (state_reg == S_IDLE);

    assign cross_zero = (cross_reg == '0);
    assign i_zero     = (i_reg == '0);
    assign cross56    = ({6'd0, cross_reg} << 6) - ({6'd0, cross_reg} << 3);
    assign bur100     = ({7'd0, bur_reg} << 6) + ({7'd0, bur_reg} << 5)
                      + ({7'd0, bur_reg} << 2);

    assign irp = (cr_reg == '0 && ci_reg == '0) ? 32'd1 : cr_reg;
    assign iip = ci_reg;
    assign vrp = (vr_reg == '0 && vi_reg == '0) ? 32'd1 : vr_reg;
    assign vip = vi_reg;
    assign msqi_p = (msqi_reg == '0) ? 64'd1 : msqi_reg;
    assign msqv_p = (msqv_reg == '0) ? 64'd1 : msqv_reg;
    assign s1 = irp[31] ^ vrp[31];
    assign s2 = iip[31] ^ vip[31];
    assign dot = (s1 ? -{2'b00, p1_reg} : {2'b00, p1_reg})
               + (s2 ? -{2'b00, mul_p[63:0]} : {2'b00, mul_p[63:0]});

    assign t2   = (mul_p[127:80] != '0) ? MAX48 : mul_p[79:32];
    assign bsum = {1'b0, bur_reg} + {1'b0, t2};
    assign qc   = (div_q > 48'd32768) ? 17'd32768 : div_q[16:0];

    // operand selection for the shared units
    always_comb
    begin
        mul_a     = '0;
        mul_b     = '0;
        mul_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        div_start = 1'b0;
        sq_rad    = '0;
        sq_iters  = '0;
        sq_start  = 1'b0;
        unique case (state_reg)
            S_SQ_RE:
            begin
                mul_a = {32'd0, abs32(re_reg)};
                mul_b = {32'd0, abs32(re_reg)};
                mul_start = go_reg;
            end
            S_SQ_IM:
            begin
                mul_a = {32'd0, abs32(im_reg)};
                mul_b = {32'd0, abs32(im_reg)};
                mul_start = go_reg;
            end
            S_RMS:
            begin
                sq_rad   = {1'b0, msq_reg[63:1], 64'd0};
                sq_iters = SQ_CW'(32);
                sq_start = go_reg;
            end
            S_RES:
            begin
                div_num   = {48'd0, length_reg, 16'd0};
                div_den   = {43'd0, cross56};
                div_start = go_reg && !cross_zero;
            end
            S_NSQ:
            begin
                mul_a = {32'd0, range_reg};
                mul_b = {32'd0, range_reg};
                mul_start = go_reg;
            end
            S_B_MUL1:
            begin
                mul_a = n2_reg;
                mul_b = {32'd0, mode_reg ? u_reg : i_reg};
                mul_start = go_reg;
            end
            S_B_MUL2:
            begin
                mul_a = {16'd0, r_reg};
                mul_b = {32'd0, i_reg};
                mul_start = go_reg && !mode_reg;
            end
            S_B_DIV:
            begin
                div_num   = num_reg;
                div_den   = den_reg;
                div_start = go_reg;
            end
            S_B_MUL3:
            begin
                mul_a = n2_reg;
                mul_b = {16'd0, r_reg};
                mul_start = go_reg;
            end
            S_REL:
            begin
                div_num   = {25'd0, bur100, 16'd0};
                div_den   = {49'd0, nombur_reg};
                div_start = go_reg;
            end
            S_PF_M1:
            begin
                mul_a = {32'd0, abs32(irp)};
                mul_b = {32'd0, abs32(vrp)};
                mul_start = go_reg;
            end
            S_PF_M2:
            begin
                mul_a = {32'd0, abs32(iip)};
                mul_b = {32'd0, abs32(vip)};
                mul_start = go_reg;
            end
            S_PF_M3:
            begin
                mul_a = msqi_p;
                mul_b = msqv_p;
                mul_start = go_reg;
            end
            S_PF_SQRT:
            begin
                sq_rad   = sq_reg;
                sq_iters = SQ_CW'(64);
                sq_start = go_reg;
            end
            S_PF_DIV:
            begin
                div_num   = {17'd0, mag_reg, 15'd0};
                div_den   = {17'd0, s_reg};
                div_start = go_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:    if (in_valid) state_next = S_SQ_RE;
            S_SQ_RE:   if (mul_done) state_next = S_SQ_IM;
            S_SQ_IM:   if (mul_done) state_next = S_RMS;
            S_RMS:     if (sq_done) state_next = S_RES;
            S_RES:     if (cross_zero || div_done) state_next = S_NSQ;
            S_NSQ:     if (mul_done) state_next = S_B_MUL1;
            S_B_MUL1:  if (mul_done) state_next = S_B_MUL2;
            S_B_MUL2:
            begin
                if (mode_reg)
                begin
                    state_next = i_zero ? S_REL : S_B_DIV;
                end
                else if (mul_done)
                begin
                    state_next = S_B_DIV;
                end
            end
            S_B_DIV:   if (div_done) state_next = mode_reg ? S_B_MUL3 : S_REL;
            S_B_MUL3:  if (mul_done) state_next = S_REL;
            S_REL:     if (div_done) state_next = S_PF_M1;
            S_PF_M1:   if (mul_done) state_next = S_PF_M2;
            S_PF_M2:   if (mul_done) state_next = S_PF_M3;
            S_PF_M3:   if (mul_done) state_next = S_PF_SQRT;
            S_PF_SQRT: if (sq_done) state_next = S_PF_DIV;
            S_PF_DIV:  if (div_done) state_next = S_FIN;
            S_FIN:     if (deliver) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            go_reg     <= 1'b0;
            ovalid_reg <= 1'b0;
            mode_reg   <= 1'b0;
            range_reg  <= 32'h0001_0000;
            nombur_reg <= 32'h0001_0000;
            length_reg <= '0;
            cross_reg  <= 32'h0001_0000;
            vr_reg     <= '0;
            vi_reg     <= '0;
            cr_reg     <= '0;
            ci_reg     <= '0;
            u_reg      <= '0;
            i_reg      <= '0;
            msqv_reg   <= '0;
            msqi_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            go_reg    <= (state_next != state_reg);
            if (deliver)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ovalid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    REG_MODE:   mode_reg   <= cfg_data[0];
                    REG_RANGE:  range_reg  <= cfg_data;
                    REG_NOMBUR: nombur_reg <= cfg_data;
                    REG_LENGTH: length_reg <= cfg_data;
                    REG_CROSS:  cross_reg  <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (accept)
            begin
                if (!opcode)
                begin
                    vr_reg <= vector_real;
                    vi_reg <= vector_imag;
                end
                else
                begin
                    cr_reg <= vector_real;
                    ci_reg <= vector_imag;
                end
            end
            if (state_reg == S_RMS && sq_done)
            begin
                if (!op_reg)
                begin
                    u_reg    <= sq_root[31:0];
                    msqv_reg <= msq_reg;
                end
                else
                begin
                    i_reg    <= sq_root[31:0];
                    msqi_reg <= msq_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= opcode;
            re_reg  <= vector_real;
            im_reg  <= vector_imag;
            err_reg <= 1'b0;
        end
        unique case (state_reg)
            S_SQ_RE:  if (mul_done) msq_reg <= mul_p[63:0];
            S_SQ_IM:  if (mul_done) msq_reg <= msq_reg + mul_p[63:0];
            S_RES:
            begin
                if (cross_zero)
                begin
                    r_reg   <= MAX48;
                    err_reg <= 1'b1;
                end
                else if (div_done)
                begin
                    r_reg <= div_q;
                end
            end
            S_NSQ:    if (mul_done) n2_reg <= mul_p[63:0];
            S_B_MUL1: if (mul_done) num_reg <= mul_p[DIV_NW-1:0];
            S_B_MUL2:
            begin
                if (mode_reg)
                begin
                    if (i_zero)
                    begin
                        bur_reg <= MAX48;
                        err_reg <= 1'b1;
                    end
                    den_reg <= {33'd0, i_reg, 16'd0};
                end
                else if (mul_done)
                begin
                    den_reg <= {33'd0, u_reg, 16'd0} + mul_p[DIV_DW-1:0];
                end
            end
            S_B_DIV:
            begin
                if (div_done)
                begin
                    bur_reg <= div_q;
                    err_reg <= err_reg | div_err;
                end
            end
            S_B_MUL3:
            begin
                if (mul_done)
                begin
                    if (bsum[48] || mul_p[127:80] != '0)
                    begin
                        err_reg <= 1'b1;
                    end
                    bur_reg <= bsum[48] ? MAX48 : bsum[47:0];
                end
            end
            S_REL:
            begin
                if (div_done)
                begin
                    rel_reg <= div_q;
                    err_reg <= err_reg | div_err;
                end
            end
            S_PF_M1:  if (mul_done) p1_reg <= mul_p[63:0];
            S_PF_M2:
            begin
                if (mul_done)
                begin
                    neg_reg <= dot[65];
                    mag_reg <= dot[65] ? 64'(-dot) : dot[63:0];
                end
            end
            S_PF_M3:   if (mul_done) sq_reg <= mul_p;
            S_PF_SQRT: if (sq_done) s_reg <= sq_root;
            S_PF_DIV:
            begin
                if (div_done)
                begin
                    if (neg_reg)
                    begin
                        pf_reg <= 16'd0 - qc[15:0];
                    end
                    else
                    begin
                        pf_reg <= (qc > 17'd32767) ? 16'd32767 : qc[15:0];
                    end
                end
            end
            S_FIN:
            begin
                if (deliver)
                begin
                    o_bur_reg <= bur_reg;
                    o_rel_reg <= rel_reg;
                    o_pf_reg  <= pf_reg;
                    o_err_reg <= err_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    tbc_mul #(
        .W (MUL_W)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_p)
    );

    tbc_div #(
        .NW (DIV_NW),
        .DW (DIV_DW),
        .QW (DIV_QW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_q),
        .err   (div_err)
    );

    tbc_sqrt #(
        .IW (SQ_IW),
        .RW (SQ_RW),
        .CW (SQ_CW)
    ) u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .rad   (sq_rad),
        .iters (sq_iters),
        .done  (sq_done),
        .root  (sq_root)
    );

    assign out_valid       = ovalid_reg;
    assign burden          = o_bur_reg;
    assign power_factor    = o_pf_reg;
    assign relative_burden = o_rel_reg;
    assign error_flag      = o_err_reg;

endmodule

[dv/tb_top.sv]
// tb_top: self-checking bench for transformer_burden_calculator_core. Directed
// table then random vector requests, checked against an in-bench burden predictor.
// Depends on tbc_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_top;
    import tbc_pkg::*;

    localparam logic OP_VOLT = 1'b0;
    localparam logic OP_CURR = 1'b1;

    typedef struct packed {
        logic [47:0] burden;
        logic [15:0] pf;
        logic [47:0] rel;
        logic        err;
    } burden_res_t;

    typedef struct {
        logic        op;
        logic [31:0] re;
        logic [31:0] im;
        bit          has_exp;
        burden_res_t exp;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        opcode = 1'b0;
    logic [31:0] vector_real = '0;
    logic [31:0] vector_imag = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [47:0] burden;
    logic [15:0] power_factor;
    logic [47:0] relative_burden;
    logic        error_flag;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_addr = '0;
    logic [31:0] cfg_data = '0;

    // predictor state
    logic        p_mode;
    logic [31:0] p_range, p_nomb, p_len, p_cross;
    logic signed [31:0] p_vr, p_vi, p_ir, p_ii;

    burden_res_t expected_q[$];
    int          n_errors = 0;
    bit          rx_done_flag = 0;

    always #4 clk = ~clk;

    transformer_burden_calculator_core u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .opcode(opcode), .vector_real(vector_real), .vector_imag(vector_imag),
        .out_valid(out_valid), .out_ready(out_ready),
        .burden(burden), .power_factor(power_factor),
        .relative_burden(relative_burden), .error_flag(error_flag),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
    );

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    function automatic logic [63:0] root_of(input logic [127:0] n);
        logic [63:0] r;
        logic [63:0] t;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (128'(t) * 128'(t) <= n) r = t;
        end
        return r;
    endfunction

    // floor division saturated to 48 bits
    function automatic logic [47:0] sat_div(input logic [127:0] num, input logic [127:0] den,
                                            inout logic err);
        logic [127:0] q;
        if (den == 0) begin
            err = 1'b1;
            return MAX48;
        end
        q = num / den;
        if (q > 128'(MAX48)) begin
            err = 1'b1;
            return MAX48;
        end
        return q[47:0];
    endfunction

    function automatic logic [63:0] sum_sq(input logic signed [63:0] re,
                                           input logic signed [63:0] im);
        return 64'(re * re) + 64'(im * im);
    endfunction

    function automatic logic [15:0] pf_calc();
        logic signed [63:0] ir, ii, vr, vi;
        logic signed [127:0] dot;
        logic [127:0] mag, q;
        logic [63:0] s;
        ir = p_ir; ii = p_ii; vr = p_vr; vi = p_vi;
        if (ir == 0 && ii == 0) ir = 1;
        if (vr == 0 && vi == 0) vr = 1;
        dot = 128'(ir * vr) + 128'(ii * vi);
        mag = dot < 0 ? 128'(-dot) : 128'(dot);
        s = root_of(128'(sum_sq(ir, ii)) * 128'(sum_sq(vr, vi)));
        q = (s == 0) ? 128'(MAX48) : (mag << 15) / s;
        if (q > 32768) q = 32768;
        if (dot < 0) return 16'(-q[16:0]);
        if (q > 32767) q = 32767;
        return q[15:0];
    endfunction

    function automatic burden_res_t burden_step(input logic op, input logic [31:0] re,
                                                input logic [31:0] im);
        burden_res_t res;
        logic err;
        logic [63:0] u, i, r, n2;
        logic [127:0] t2;
        logic [63:0] b;
        err = 1'b0;
        if (op == OP_VOLT) begin
            p_vr = re; p_vi = im;
        end else begin
            p_ir = re; p_ii = im;
        end
        u = root_of(128'(sum_sq(p_vr, p_vi) >> 1));
        i = root_of(128'(sum_sq(p_ir, p_ii) >> 1));
        n2 = 64'(p_range) * 64'(p_range);
        if (p_cross == 0) begin
            r = 64'(MAX48);
            err = 1'b1;
        end else begin
            r = (64'(p_len) << 16) / (64'(p_cross) * 64'd56);
        end
        if (!p_mode) begin
            b = sat_div(128'(n2) * 128'(i), (128'(u) << 16) + 128'(r) * 128'(i), err);
        end else if (i == 0) begin
            b = MAX48;
            err = 1'b1;
        end else begin
            b = sat_div(128'(n2) * 128'(u), 128'(i) << 16, err);
            t2 = (128'(n2) * 128'(r)) >> 32;
            if (t2 > 128'(MAX48)) begin
                t2 = 128'(MAX48);
                err = 1'b1;
            end
            b = b + t2[63:0];
            if (b > 64'(MAX48)) begin
                b = MAX48;
                err = 1'b1;
            end
        end
        res.burden = b[47:0];
        res.rel = sat_div((128'(b) * 100) << 16, 128'(p_nomb), err);
        res.pf = pf_calc();
        res.err = err;
        return res;
    endfunction

    task automatic write_reg(input reg_index_t idx, input logic [31:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_MODE:   p_mode = v[0];
            REG_RANGE:  p_range = v;
            REG_NOMBUR: p_nomb = v;
            REG_LENGTH: p_len = v;
            REG_CROSS:  p_cross = v;
            default: ;
        endcase
    endtask

    // valid drops only when a real gap follows
    task automatic idle_gap();
        int n;
        n = $urandom_range(0, 99);
        if (n < 50) n = 0;
        else if (n < 92) n = $urandom_range(1, 4);
        else n = $urandom_range(20, 600);
        if (n > 0) in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic send_request(input logic op, input logic [31:0] re, input logic [31:0] im,
                                input bit has_exp, input burden_res_t fixed);
        burden_res_t e;
        e = burden_step(op, re, im);
        if (has_exp) e = fixed;
        opcode <= op;
        vector_real <= re;
        vector_imag <= im;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        expected_q.push_back(e);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_vec();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'(signed'($urandom_range(0, 2000000)) - 1000000);
            3: return 32'd0;
            default: return $urandom();
        endcase
    endfunction

    task automatic random_config();
        write_reg(REG_MODE, $urandom());
        write_reg(REG_RANGE, $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 1 << 20));
        write_reg(REG_NOMBUR, $urandom_range(0, 7) == 0 ? 32'd0 : $urandom());
        write_reg(REG_LENGTH, $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 1 << 22));
        write_reg(REG_CROSS, $urandom_range(0, 7) == 0 ? 32'd0 : $urandom());
    endtask

    // result side
    always @(posedge clk) begin
        burden_res_t e;
        if (rst_n && out_valid && out_ready) begin
            if (expected_q.size() == 0) begin
                report("unexpected result", burden, 0);
            end else begin
                e = expected_q.pop_front();
                if (burden !== e.burden) report("burden", burden, e.burden);
                if (power_factor !== e.pf) report("power_factor", power_factor, e.pf);
                if (relative_burden !== e.rel) report("relative_burden", relative_burden, e.rel);
                if (error_flag !== e.err) report("error_flag", error_flag, e.err);
            end
        end
    end

    always @(posedge clk) begin
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) out_ready <= 1'b1;
        else if (r < 97) out_ready <= 1'b0;
        else out_ready <= ($urandom_range(0, 1) == 1);
    end

    initial begin
        stim_row_t rows[$];
        stim_row_t row;
        rows = '{
            '{OP_VOLT, 32'd0, 32'd0, 1, '{MAX48, 16'sd32767, MAX48, 1'b1}},
            '{OP_CURR, 32'h0001_0000, 32'd0, 0, '0},
            '{OP_VOLT, 32'h0001_0000, 32'd0, 0, '0},
            '{OP_VOLT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, '0},
            '{OP_CURR, 32'h8000_0000, 32'h8000_0000, 0, '0},
            '{OP_CURR, 32'h8000_0000, 32'h7FFF_FFFF, 0, '0},
            '{OP_VOLT, 32'hFFFF_0000, 32'd0, 0, '0},
            '{OP_CURR, 32'd0, 32'h0001_0000, 0, '0},
            '{OP_CURR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, '0},
            '{OP_VOLT, 32'd1, 32'd0, 0, '0},
            '{OP_CURR, 32'd0, 32'd0, 0, '0}
        };
        p_mode = 0; p_range = 32'h10000; p_nomb = 32'h10000; p_len = 0; p_cross = 32'h10000;
        p_vr = 0; p_vi = 0; p_ir = 0; p_ii = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (rows[k]) begin
            row = rows[k];
            send_request(row.op, row.re, row.im, row.has_exp, row.exp);
            idle_gap();
        end
        drain();
        // extremes of configuration
        write_reg(REG_MODE, 32'd1);
        write_reg(REG_RANGE, 32'hFFFF_FFFF);
        write_reg(REG_NOMBUR, 32'd0);
        write_reg(REG_LENGTH, 32'hFFFF_FFFF);
        write_reg(REG_CROSS, 32'd0);
        for (int k = 0; k < 6; k++) send_request(k[0], rand_vec(), rand_vec(), 0, '0);
        drain();
        write_reg(REG_MODE, 32'd0);
        write_reg(REG_RANGE, 32'd0);
        write_reg(REG_NOMBUR, 32'hFFFF_FFFF);
        write_reg(REG_LENGTH, 32'd0);
        write_reg(REG_CROSS, 32'hFFFF_FFFF);
        for (int k = 0; k < 4; k++) send_request(k[0], rand_vec(), rand_vec(), 0, '0);
        drain();

        for (int ph = 0; ph < 11; ph++) begin
            random_config();
            for (int k = 0; k < 48; k++) begin
                send_request($urandom_range(0, 1), rand_vec(), rand_vec(), 0, '0);
                if (k == 20) begin
                    in_valid <= 1'b0;
                    while (expected_q.size() != 0) @(posedge clk);
                end
                else idle_gap();
            end
            drain();
        end
        repeat (500) @(posedge clk);
        rx_done_flag = 1;
    end

    initial begin
        wait (rx_done_flag);
        if (n_errors == 0 && expected_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule

[sim.f]
hdl/tbc_pkg.sv
hdl/tbc_mul.sv
hdl/tbc_div.sv
hdl/tbc_sqrt.sv
hdl/transformer_burden_calculator_core.sv
dv/tb_top.sv
